### rtl/ciss_pkg.sv
package ciss_pkg;

    localparam int MAX_PATTERN   = 16;
    localparam int CHAR_BITS     = 16;
    localparam int POS_BITS      = 16;
    localparam int STORED_CHARS  = 16;
    localparam int REG_CHARS     = 4;
    localparam int PAT_REGS      = STORED_CHARS / REG_CHARS;
    localparam int PAT_SEL_BITS  = $clog2(PAT_REGS);
    localparam int IDX_BITS      = $clog2(MAX_PATTERN);
    localparam int LEN_BITS      = $clog2(MAX_PATTERN + 1) + 1;
    localparam int RAW_LEN_BITS  = 5;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 3;
    localparam int REG_CHAR_BITS = 16;
    localparam int IN_DATA_BITS  = ((CHAR_BITS + 7) / 8) * 8;
    localparam int OUT_USED_BITS = 1 + POS_BITS + 1;
    localparam int OUT_DATA_BITS = ((OUT_USED_BITS + 7) / 8) * 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LOW      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_MID_LOW  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_MID_HIGH = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_HIGH     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_PAT_LENGTH   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_OFFSET = 3'd5;

    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = CHAR_BITS'(8'h41);
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_Z = CHAR_BITS'(8'h5A);
    localparam logic [CHAR_BITS-1:0] CHAR_CASE    = CHAR_BITS'(8'h20);

    typedef enum logic {
        OP_CHAR  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    typedef struct packed {
        op_t                  kind;
        logic [CHAR_BITS-1:0] chr;
    } item_t;

    typedef struct packed {
        logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] pat;
        logic [MAX_PATTERN-1:0]                mask;
        logic [LEN_BITS-1:0]                   len;
        logic [POS_BITS-1:0]                   start;
    } cfg_t;

    function automatic logic [CHAR_BITS-1:0] fold(input logic [CHAR_BITS-1:0] c);
        logic [CHAR_BITS-1:0] r;
        r = c;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r = c + CHAR_CASE;
        end
        return r;
    endfunction

endpackage

### rtl/ciss_cfg.sv
module ciss_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ciss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ciss_pkg::CFG_DATA_BITS-1:0] cfg_data,
    output ciss_pkg::cfg_t                cfg
);
    import ciss_pkg::*;

    logic [PAT_REGS-1:0][CFG_DATA_BITS-1:0] pat_reg;
    logic [RAW_LEN_BITS-1:0]                raw_len_reg;
    logic [POS_BITS-1:0]                    start_reg;
    logic [LEN_BITS-1:0]                    len_reg;
    logic [LEN_BITS-1:0]                    len_next;
    cfg_t                                   cfg_reg;
    cfg_t                                   cfg_next;
    logic [MAX_PATTERN-1:0][CHAR_BITS-1:0]  pchar;
    logic [LEN_BITS-1:0]                    lim;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            if (k < STORED_CHARS)
            begin
                pchar[k] = CHAR_BITS'(pat_reg[k / REG_CHARS][(k % REG_CHARS) * REG_CHAR_BITS +:
                                                             REG_CHAR_BITS]);
            end
            else
            begin
                pchar[k] = '0;
            end
        end
    end

    // Clamp the length, then stop at the first zero character.
    always_comb
    begin
        lim = LEN_BITS'(raw_len_reg);
        if (lim > LEN_BITS'(MAX_PATTERN))
        begin
            lim = LEN_BITS'(MAX_PATTERN);
        end
        if (lim > LEN_BITS'(STORED_CHARS))
        begin
            lim = LEN_BITS'(STORED_CHARS);
        end
        len_next = lim;
        for (int k = MAX_PATTERN - 1; k >= 0; k--)
        begin
            if (LEN_BITS'(k) < lim && pchar[k] == '0)
            begin
                len_next = LEN_BITS'(k);
            end
        end
    end

    // Align the pattern to the newest end of the window.
    always_comb
    begin
        logic [LEN_BITS-1:0] sum;
        cfg_next       = cfg_reg;
        cfg_next.len   = len_reg;
        cfg_next.start = start_reg;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            sum              = LEN_BITS'(j) + len_reg;
            cfg_next.mask[j] = (sum >= LEN_BITS'(MAX_PATTERN));
            cfg_next.pat[j]  = fold(pchar[sum[IDX_BITS-1:0]]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg     <= '0;
            raw_len_reg <= '0;
            start_reg   <= '0;
            len_reg     <= '0;
            cfg_reg     <= '0;
        end
        else
        begin
            len_reg <= len_next;
            cfg_reg <= cfg_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index) inside
                    REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH:
                    begin
                        pat_reg[cfg_index[PAT_SEL_BITS-1:0]] <= cfg_data;
                    end
                    REG_PAT_LENGTH:
                    begin
                        raw_len_reg <= cfg_data[RAW_LEN_BITS-1:0];
                    end
                    REG_START_OFFSET:
                    begin
                        start_reg <= cfg_data[POS_BITS-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

endmodule

### rtl/ciss_front.sv
module ciss_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ciss_pkg::IN_DATA_BITS-1:0] in_data,
    input  logic                             in_last,
    output logic                             push_valid,
    input  logic                             push_ready,
    output ciss_pkg::item_t                  push_item
);
    import ciss_pkg::*;

    logic                 valid_reg;
    logic                 valid_next;
    item_t                item_reg;
    item_t                item_next;
    logic [CHAR_BITS-1:0] chr;

    assign chr        = in_data[CHAR_BITS-1:0];
    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg && !push_ready;
        item_next  = item_reg;
        if (in_valid && in_ready)
        begin
            valid_next     = 1'b1;
            item_next.kind = (in_last || chr == '0) ? OP_CLOSE : OP_CHAR;
            item_next.chr  = fold(chr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

### rtl/ciss_queue.sv
module ciss_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  ciss_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output ciss_pkg::item_t pop_item
);
    import ciss_pkg::*;

    item_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_reg;
    logic [QPTR_BITS-1:0]  wr_next;
    logic [QPTR_BITS-1:0]  rd_reg;
    logic [QPTR_BITS-1:0]  rd_next;
    logic [QCNT_BITS-1:0]  cnt_reg;
    logic [QCNT_BITS-1:0]  cnt_next;
    logic                  push;
    logic                  pop;

    assign push_ready = (cnt_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

### rtl/ciss_back.sv
module ciss_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ciss_pkg::cfg_t                    cfg,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  ciss_pkg::item_t                   item,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ciss_pkg::OUT_DATA_BITS-1:0] out_data
);
    import ciss_pkg::*;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] win_reg;
    logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] win_next;
    logic [MAX_PATTERN-1:0][CHAR_BITS-1:0] win_shift;
    logic [POS_BITS-1:0]                   cnt_reg;
    logic [POS_BITS-1:0]                   cnt_next;
    logic                                  seen_reg;
    logic                                  seen_next;
    logic [POS_BITS-1:0]                   first_reg;
    logic [POS_BITS-1:0]                   first_next;
    logic                                  ovf_reg;
    logic                                  ovf_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    logic [OUT_DATA_BITS-1:0]              out_data_reg;
    logic [OUT_DATA_BITS-1:0]              out_data_next;
    logic [MAX_PATTERN-1:0]                lane_ok;
    logic [POS_BITS-1:0]                   cnt_inc;
    logic [POS_BITS-1:0]                   plen;
    logic [POS_BITS-1:0]                   start_pos;
    logic                                  hit;
    logic                                  pop;
    logic                                  found;
    logic [POS_BITS-1:0]                   position;

    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;
    assign item_ready = (item.kind == OP_CHAR) || !out_valid_reg || out_ready;
    assign pop        = item_valid && item_ready;
    assign plen       = POS_BITS'(cfg.len);
    assign cnt_inc    = cnt_reg + 1'b1;
    assign start_pos  = cnt_inc - plen;

    always_comb
    begin
        for (int j = 0; j < MAX_PATTERN - 1; j++)
        begin
            win_shift[j] = win_reg[j + 1];
        end
        win_shift[MAX_PATTERN-1] = item.chr;
        for (int j = 0; j < MAX_PATTERN; j++)
        begin
            lane_ok[j] = !cfg.mask[j] || (win_shift[j] == cfg.pat[j]);
        end
    end

    assign hit = (plen != '0) && !seen_reg && (cnt_inc >= plen) &&
                 (start_pos >= cfg.start) && (&lane_ok);

    always_comb
    begin
        found    = 1'b0;
        position = '0;
        if (plen == '0)
        begin
            found = 1'b1;
        end
        else if (cfg.start > cnt_reg)
        begin
            found = 1'b0;
        end
        else if (seen_reg)
        begin
            found    = 1'b1;
            position = first_reg;
        end
    end

    always_comb
    begin
        win_next       = win_reg;
        cnt_next       = cnt_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (pop)
        begin
            if (item.kind == OP_CHAR)
            begin
                if (cnt_reg == POS_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    win_next = win_shift;
                    cnt_next = cnt_inc;
                    if (hit)
                    begin
                        seen_next  = 1'b1;
                        first_next = start_pos;
                    end
                end
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = OUT_DATA_BITS'({ovf_reg, position, found});
                win_next       = '0;
                cnt_next       = '0;
                seen_next      = 1'b0;
                first_next     = '0;
                ovf_next       = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg       <= '0;
            cnt_reg       <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            win_reg       <= win_next;
            cnt_reg       <= cnt_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/case_insensitive_substring_search_unit.sv
// Case-insensitive substring search over a streamed text.
// Configuration: write cfg_index/cfg_data with cfg_valid (cfg_ready is always high):
// registers 0-3 hold the sixteen pattern characters, 4 the pattern length,
// 5 the start offset. Write only while no text is in flight.
// Input stream (s_axis): one 16-bit character per transaction in tdata; tlast, or a
// zero character, closes the text. Accepts one transaction per clock while the
// internal queue has room.
// Output stream (m_axis): one result transaction per closed text; characters give none.
// A closing transaction passes from the input register into the queue, and the search
// engine pops it from there and loads the result into the output register.
// Throughput is one character per cycle while the queue has room, set by the combinational
// sixteen-lane window compare in the search engine.
// While m_axis_tready is low the result holds; characters keep flowing, and a
// following closing transaction waits in the queue until the output register frees;
// s_axis_tready drops once the queue and the input register fill behind it.
// Reset clears the configuration to zero, empties the queue and clears the text state.
module case_insensitive_substring_search_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ciss_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [ciss_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ciss_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,  // [15:0] text_char
    input  logic                               s_axis_tlast,  // end_of_text
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] found, [16:1] match_position, [17] text_too_long, rest zero
    output logic [ciss_pkg::OUT_DATA_BITS-1:0] m_axis_tdata
);
    import ciss_pkg::*;

    cfg_t  cfg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    ciss_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ciss_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_data    (s_axis_tdata),
        .in_last    (s_axis_tlast),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    ciss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    ciss_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (pop_valid),
        .item_ready (pop_ready),
        .item       (pop_item),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (m_axis_tdata)
    );

endmodule

### tb/sv/testbench.sv
module testbench;
    import ciss_pkg::*;

    typedef struct packed {
        logic                found;
        logic [POS_BITS-1:0] position;
        logic                too_long;
    } search_result_t;

    class search_scoreboard;
        logic [CHAR_BITS-1:0]    pattern [STORED_CHARS];
        logic [RAW_LEN_BITS-1:0] pattern_len;
        logic [POS_BITS-1:0]     start_index;
        logic [CHAR_BITS-1:0]    window [MAX_PATTERN];
        int unsigned             text_len;
        bit                      match_hit;
        logic [POS_BITS-1:0]     match_index;
        bit                      overflowed;
        search_result_t          expected_q [$];
        int                      errors;
        int                      results_seen;
        int                      found_count;
        int                      overflows;
        int                      writes;

        function new();
            foreach (pattern[k])
            begin
                pattern[k] = '0;
            end
            pattern_len = '0;
            start_index = '0;
            errors = 0;
            results_seen = 0;
            found_count = 0;
            overflows = 0;
            writes = 0;
            clear_text();
        endfunction

        function void clear_text();
            foreach (window[k])
            begin
                window[k] = '0;
            end
            text_len = 0;
            match_hit = 1'b0;
            match_index = '0;
            overflowed = 1'b0;
        endfunction

        function logic [CHAR_BITS-1:0] lower_ascii(logic [CHAR_BITS-1:0] c);
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                return c + CHAR_CASE;
            end
            return c;
        endfunction

        function int active_length();
            int lim;
            lim = (pattern_len > MAX_PATTERN) ? MAX_PATTERN : int'(pattern_len);
            if (lim > STORED_CHARS)
            begin
                lim = STORED_CHARS;
            end
            for (int k = 0; k < lim; k++)
            begin
                if (pattern[k] == '0)
                begin
                    return k;
                end
            end
            return lim;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void set_register(logic [CFG_IDX_BITS-1:0] index,
                                   logic [CFG_DATA_BITS-1:0] value);
            int base;
            writes++;
            case (index)
                REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH:
                begin
                    base = int'(index) * REG_CHARS;
                    for (int j = 0; j < REG_CHARS; j++)
                    begin
                        pattern[base + j] = value[j * REG_CHAR_BITS +: CHAR_BITS];
                    end
                end
                REG_PAT_LENGTH:
                    pattern_len = value[RAW_LEN_BITS-1:0];
                REG_START_OFFSET:
                    start_index = value[POS_BITS-1:0];
                default:
                    ;
            endcase
        endfunction

        function void note_text_item(logic [CHAR_BITS-1:0] chr, op_t kind);
            int unsigned    plen;
            int unsigned    s;
            bit             same;
            search_result_t r;
            plen = active_length();
            if (kind == OP_CHAR && chr != '0)
            begin
                // drop characters once the length counter saturates
                if (text_len >= (1 << POS_BITS) - 1)
                begin
                    overflowed = 1'b1;
                    return;
                end
                for (int k = 0; k < MAX_PATTERN - 1; k++)
                begin
                    window[k] = window[k + 1];
                end
                window[MAX_PATTERN - 1] = chr;
                text_len++;
                if (plen > 0 && !match_hit && text_len >= plen)
                begin
                    s = text_len - plen;
                    same = 1'b1;
                    for (int k = 0; k < plen; k++)
                    begin
                        if (lower_ascii(window[MAX_PATTERN - plen + k])
                            != lower_ascii(pattern[k]))
                        begin
                            same = 1'b0;
                        end
                    end
                    if (same && s >= start_index)
                    begin
                        match_hit = 1'b1;
                        match_index = s[POS_BITS-1:0];
                    end
                end
                return;
            end
            r.found = 1'b0;
            r.position = '0;
            r.too_long = overflowed;
            if (plen == 0)
            begin
                r.found = 1'b1;
            end
            else if (start_index <= text_len && match_hit)
            begin
                r.found = 1'b1;
                r.position = match_index;
            end
            if (r.found)
            begin
                found_count++;
            end
            if (r.too_long)
            begin
                overflows++;
            end
            expected_q.push_back(r);
            clear_text();
        endfunction

        function void check_result(logic [OUT_DATA_BITS-1:0] data);
            search_result_t want;
            if (expected_q.size() == 0)
            begin
                $error("result 0x%0h arrived with no closed text waiting", data);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            results_seen++;
            if (data[0] !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, data[0]);
                errors++;
            end
            if (data[POS_BITS:1] !== want.position)
            begin
                $error("match_position: expected %0d, actual %0d",
                       want.position, data[POS_BITS:1]);
                errors++;
            end
            if (data[POS_BITS+1] !== want.too_long)
            begin
                $error("text_too_long: expected %0d, actual %0d",
                       want.too_long, data[POS_BITS+1]);
                errors++;
            end
            if (data[OUT_DATA_BITS-1:POS_BITS+2] !== '0)
            begin
                $error("padding: expected 0, actual 0x%0h", data[OUT_DATA_BITS-1:POS_BITS+2]);
                errors++;
            end
        endfunction
    endclass

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1450;

    localparam logic [CHAR_BITS-1:0] BORDER_CODES [10] = '{
        16'h0040, 16'h005B, 16'h0060, 16'h007B, 16'h0041,
        16'h005A, 16'h0061, 16'h007A, 16'hFFFF, 16'h8000
    };
    localparam logic [CFG_IDX_BITS-1:0] PAT_REG_INDEX [PAT_REGS] = '{
        REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH
    };

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata;
    logic                     s_axis_tlast;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;

    search_scoreboard board = new();
    int idle_pct = 26;
    bit hold_request = 1'b0;
    int items_sent = 0;

    case_insensitive_substring_search_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [CHAR_BITS-1:0] char_pick(input int letter_pct, input int border_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < letter_pct)
        begin
            return (($urandom_range(1) == 1) ? CHAR_UPPER_A : CHAR_UPPER_A + CHAR_CASE)
                   + CHAR_BITS'($urandom_range(3));
        end
        if (roll < letter_pct + border_pct)
        begin
            return BORDER_CODES[$urandom_range(9)];
        end
        return CHAR_BITS'($urandom_range(65535, 1));
    endfunction

    task automatic send_item(input logic [CHAR_BITS-1:0] chr, input op_t kind);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_BITS'(chr);
        s_axis_tlast <= (kind == OP_CLOSE);
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        board.note_text_item(chr, kind);
        items_sent++;
    endtask

    task automatic close_text(input bit by_last);
        if (by_last)
        begin
            send_item(CHAR_BITS'($urandom_range(65535)), OP_CLOSE);
        end
        else
        begin
            send_item('0, OP_CHAR);
        end
    endtask

    task automatic send_chars(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_item(CHAR_BITS'(s[i]), OP_CHAR);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        board.set_register(index, value);
    endtask

    task automatic wait_quiet();
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        logic [CHAR_BITS-1:0]     chars [STORED_CHARS];
        logic [CHAR_BITS-1:0]     body [$];
        logic [CHAR_BITS-1:0]     c;
        logic [CHAR_BITS-1:0]     lc;
        logic [CFG_DATA_BITS-1:0] data;
        int phase, style, pick, len_val, offset_val, texts;
        int n, plen, at, k, i, t, start_items;

        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        s_axis_tlast <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern out of reset, closed by tlast and by a zero character
        close_text(1'b1);
        send_item(16'hFFFF, OP_CHAR);
        close_text(1'b0);

        // early match before the start offset must be skipped
        wait_quiet();
        write_reg(REG_PAT_LOW, {16'h0000, 16'h0043, 16'h0062, 16'h0041});
        write_reg(REG_PAT_LENGTH, 64'd3);
        write_reg(REG_START_OFFSET, 64'd2);
        cfg_valid <= 1'b0;
        send_chars("aBcxABC");
        close_text(1'b1);

        // start offset beyond the text
        wait_quiet();
        write_reg(REG_START_OFFSET, 64'd20);
        cfg_valid <= 1'b0;
        send_chars("abc");
        close_text(1'b0);

        // zero inside the pattern cuts it short
        wait_quiet();
        write_reg(REG_PAT_LOW, {16'h0064, 16'h0000, 16'h0062, 16'h0061});
        write_reg(REG_PAT_LENGTH, 64'd4);
        write_reg(REG_START_OFFSET, 64'd0);
        cfg_valid <= 1'b0;
        send_chars("xAB");
        close_text(1'b1);

        // all-ones pattern, oversized length clipped to the stored characters
        wait_quiet();
        for (k = 0; k < PAT_REGS; k++)
        begin
            write_reg(PAT_REG_INDEX[k], '1);
        end
        write_reg(REG_PAT_LENGTH, '1);
        write_reg(REG_START_OFFSET, 64'hFFFF_FFFF_FFFF_0000);
        cfg_valid <= 1'b0;
        for (k = 0; k < 3; k++)
        begin
            send_item(16'hFFFF, OP_CHAR);
        end
        close_text(1'b0);

        phase = 0;
        start_items = items_sent;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            wait_quiet();
            style = $urandom_range(9);
            for (k = 0; k < STORED_CHARS; k++)
            begin
                chars[k] = (style == 0) ? '1 : (style == 1) ? '0 : char_pick(85, 10);
            end
            if (style == 2)
            begin
                chars[$urandom_range(STORED_CHARS - 1)] = '0;
            end
            for (k = 0; k < PAT_REGS; k++)
            begin
                if (phase == 0 || $urandom_range(1) == 1)
                begin
                    write_reg(PAT_REG_INDEX[k], {chars[REG_CHARS*k+3], chars[REG_CHARS*k+2],
                                                 chars[REG_CHARS*k+1], chars[REG_CHARS*k]});
                end
            end
            pick = $urandom_range(99);
            len_val = (pick < 8) ? 0 : (pick < 70) ? $urandom_range(1, 6) :
                      (pick < 85) ? $urandom_range(7, 16) : $urandom_range(17, 31);
            if (phase == 1)
            begin
                len_val = 31;
            end
            if (phase == 3)
            begin
                len_val = MAX_PATTERN;
            end
            data = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
            data[RAW_LEN_BITS-1:0] = len_val[RAW_LEN_BITS-1:0];
            if (phase < 6 || $urandom_range(1) == 1)
            begin
                write_reg(REG_PAT_LENGTH, data);
            end
            pick = $urandom_range(99);
            offset_val = (pick < 55) ? $urandom_range(0, 6) : (pick < 80) ? $urandom_range(0, 40) :
                         (pick < 90) ? 65535 : $urandom_range(65535);
            if (phase == 5)
            begin
                offset_val = 65535;
            end
            data = ($urandom_range(3) == 0) ? {$urandom, $urandom} : '0;
            data[POS_BITS-1:0] = offset_val[POS_BITS-1:0];
            if (phase < 6 || $urandom_range(1) == 1)
            begin
                write_reg(REG_START_OFFSET, data);
            end
            cfg_valid <= 1'b0;

            idle_pct = (phase == 4) ? 0 : 26;
            if (phase == 2)
            begin
                hold_request = 1'b1;
            end
            texts = (phase == 2) ? 40 : (phase == 4) ? 20 : $urandom_range(4, 12);
            for (t = 0; t < texts; t++)
            begin
                body.delete();
                n = (phase == 2) ? $urandom_range(0, 2) :
                    ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 20);
                for (i = 0; i < n; i++)
                begin
                    body.push_back(char_pick(75, 13));
                end
                plen = board.active_length();
                // plant the pattern, or a prefix of it, with random case
                if (phase != 2 && plen > 0 && $urandom_range(99) < 65)
                begin
                    at = $urandom_range(body.size());
                    k = ($urandom_range(4) == 0) ? $urandom_range(1, plen) : plen;
                    for (i = k - 1; i >= 0; i--)
                    begin
                        c = board.pattern[i];
                        lc = board.lower_ascii(c);
                        if (lc >= CHAR_UPPER_A + CHAR_CASE && lc <= CHAR_UPPER_Z + CHAR_CASE
                            && $urandom_range(1) == 1)
                        begin
                            c = c ^ CHAR_CASE;
                        end
                        body.insert(at, c);
                    end
                end
                for (i = 0; i < body.size(); i++)
                begin
                    send_item(body[i], OP_CHAR);
                end
                close_text($urandom_range(1));
            end
            phase++;
        end
        idle_pct = 26;
        wait_quiet();

        $display("Checked %0d search results (%0d found, %0d overflowed) from %0d text transactions,",
                 board.results_seen, board.found_count, board.overflows, items_sent);
        $display("over %0d register writes, empty to clipped patterns, offsets up to the maximum.",
                 board.writes);
        if (board.errors == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                board.check_result(m_axis_tdata);
            end
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end
endmodule

### case_insensitive_substring_search_unit.f
rtl/ciss_pkg.sv
rtl/ciss_cfg.sv
rtl/ciss_front.sv
rtl/ciss_queue.sv
rtl/ciss_back.sv
rtl/case_insensitive_substring_search_unit.sv
tb/sv/testbench.sv
